@@ sv/round_robin_thread_scheduler_unit_assert.svh @@
// Assertion macros for the round-robin thread scheduler unit.
// Included by the top level; uses its clk and arst_n ports.
`ifndef ROUND_ROBIN_THREAD_SCHEDULER_UNIT_ASSERT_SVH
`define ROUND_ROBIN_THREAD_SCHEDULER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define RRTS_ASSERT_IMPL(lbl, pre, con) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (con)) \
		else $error("rrts assertion failed");
`define RRTS_ASSERT_NEXT(lbl, pre, con) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (con)) \
		else $error("rrts assertion failed");
`else
`define RRTS_ASSERT_IMPL(lbl, pre, con)
`define RRTS_ASSERT_NEXT(lbl, pre, con)
`endif
`endif

@@ sv/rrts_pkg.sv @@
// Shared constants, codes and types of the round-robin thread scheduler.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package rrts_pkg;
	localparam int NUM_SLOTS = 16;
	localparam int SLOT_W = 4;
	localparam int CNT_W = 5;
	localparam logic [CNT_W-1:0] CNT_MAX = 5'd31;

	localparam logic [2:0] REQ_TICK = 3'd0;
	localparam logic [2:0] REQ_YIELD = 3'd1;
	localparam logic [2:0] REQ_CREATE = 3'd2;
	localparam logic [2:0] REQ_STOP = 3'd3;
	localparam logic [2:0] REQ_SUSPEND = 3'd4;
	localparam logic [2:0] REQ_RESUME = 3'd5;
	localparam logic [2:0] REQ_DELAY = 3'd6;

	localparam logic [2:0] SS_UNUSED = 3'd0;
	localparam logic [2:0] SS_RUNNING = 3'd1;
	localparam logic [2:0] SS_READY = 3'd2;
	localparam logic [2:0] SS_BLOCKED = 3'd3;
	localparam logic [2:0] SS_SUSPENDED = 3'd4;

	localparam logic [2:0] ST_SWITCHED = 3'd0;
	localparam logic [2:0] ST_NO_READY = 3'd1;
	localparam logic [2:0] ST_CREATED = 3'd2;
	localparam logic [2:0] ST_FULL = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_PRE,
		PH_CREATE,
		PH_WAKE,
		PH_SCAN,
		PH_SWAP,
		PH_FIN
	} phase_t;

	typedef struct packed {
		logic load;
		phase_t phase;
	} cmd_t;

	typedef struct packed {
		logic is_create;
		logic go_yield;
		logic go_wake;
		logic hit;
		logic last;
	} sts_t;

	typedef struct packed {
		logic [CNT_W-1:0] waiting;
		logic [SLOT_W-1:0] handle;
		logic [SLOT_W-1:0] previous;
		logic [SLOT_W-1:0] running;
		logic [2:0] status;
	} res_t;
endpackage
`default_nettype wire

@@ sv/round_robin_thread_scheduler_unit.sv @@
// Top level of the round-robin thread scheduler: stream ports, mode register,
// result register and assertions. Uses rrts_pkg, rrts_ctrl, rrts_dp and the assert header.
`timescale 1ns / 1ps
`default_nettype none
// Each request word produces exactly one result word. A request that needs no
// scan passes through the pre and finish states only; a create also searches
// the slot table, and a yield may wake expired threads and then scan. The slot
// table has a single port that the wake pass and the round-robin scan each
// walk one slot per cycle. A finished result waits in an output register, and
// the next request is accepted while it waits.
module round_robin_thread_scheduler_unit (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_wr_en,
	input wire logic cfg_wr_data, // preemptive_mode
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	// req_type[2:0], target_slot[6:3], target_is_current[7], delay_ms[39:8]
	input wire logic [39:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	// status[2:0], running_slot[6:3], previous_slot[10:7], new_handle[14:11],
	// waiting_count[19:15], zero[23:20]
	output logic [23:0] m_axis_tdata
);
	import rrts_pkg::*;
	`include "round_robin_thread_scheduler_unit_assert.svh"

	logic preempt_q, out_valid_q, out_load, out_free;
	res_t res, out_q;
	cmd_t cmd;
	sts_t sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			preempt_q <= 1'b0;
		end else if (cfg_wr_en) begin
			preempt_q <= cfg_wr_data;
		end
	end

	assign out_free = !out_valid_q || m_axis_tready;

	rrts_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_axis_tvalid),
		.out_free(out_free),
		.sts(sts),
		.in_ready(s_axis_tready),
		.out_load(out_load),
		.cmd(cmd)
	);

	rrts_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.preemptive_mode(preempt_q),
		.req_type(s_axis_tdata[2:0]),
		.target_slot(s_axis_tdata[6:3]),
		.target_is_current(s_axis_tdata[7]),
		.delay_ms(s_axis_tdata[39:8]),
		.sts(sts),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {4'd0, out_q};

	`RRTS_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)
	`RRTS_ASSERT_IMPL(a_status_legal, out_valid_q, out_q.status <= ST_DONE)
	`RRTS_ASSERT_IMPL(a_waiting_only_idle, out_valid_q && out_q.waiting != '0, out_q.status == ST_NO_READY)
	`RRTS_ASSERT_IMPL(a_handle_only_create, out_valid_q && out_q.handle != '0, out_q.status == ST_CREATED)
endmodule
`default_nettype wire

@@ sv/rrts_dp.sv @@
// Datapath of the thread scheduler: slot table, deadlines, time and result.
// Driven by rrts_ctrl through cmd_t; depends on rrts_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rrts_dp (
	input wire logic clk,
	input wire logic arst_n,
	input wire rrts_pkg::cmd_t cmd,
	input wire logic preemptive_mode,
	input wire logic [2:0] req_type,
	input wire logic [3:0] target_slot,
	input wire logic target_is_current,
	input wire logic [31:0] delay_ms,
	output rrts_pkg::sts_t sts,
	output rrts_pkg::res_t res
);
	import rrts_pkg::*;

	logic [2:0] slot_state_q [NUM_SLOTS];
	logic [31:0] deadline_q [NUM_SLOTS];
	logic [SLOT_W-1:0] cur_q, prev_q, tgt_q, idx_q, old_q, handle_q;
	logic [31:0] time_q, dms_q;
	logic [2:0] req_q, status_q;
	logic tcur_q, cur_run_q;
	logic [CNT_W-1:0] cnt_q, wait_q, cnt_nxt;

	logic [SLOT_W-1:0] addr;
	logic [2:0] rd_state, wr_state;
	logic [31:0] elapsed, wr_dl;
	logic expired, susp_ok, cur_nz, st_we, dl_we, waiter;

	always_comb begin
		unique case (cmd.phase)
			PH_PRE: begin
				if (req_q == REQ_SUSPEND) begin
					addr = tcur_q ? cur_q : tgt_q;
				end else if (req_q == REQ_RESUME) begin
					addr = tgt_q;
				end else begin
					addr = cur_q;
				end
			end
			PH_SCAN: addr = SLOT_W'(cur_q + idx_q);
			PH_SWAP: addr = old_q;
			default: addr = idx_q;
		endcase
	end

	assign rd_state = slot_state_q[addr];
	assign elapsed = time_q - deadline_q[addr];
	assign expired = (rd_state == SS_BLOCKED) && !elapsed[31];
	assign susp_ok = (rd_state == SS_RUNNING) || (rd_state == SS_READY) ||
		(rd_state == SS_BLOCKED);
	assign cur_nz = (cur_q != '0);
	assign waiter = (rd_state == SS_BLOCKED) || (rd_state == SS_SUSPENDED);
	assign cnt_nxt = (waiter && cnt_q != CNT_MAX) ? cnt_q + 5'd1 : cnt_q;

	always_comb begin
		sts.is_create = (req_q == REQ_CREATE);
		sts.go_wake = (req_q == REQ_TICK) || !preemptive_mode;
		sts.last = (idx_q == SLOT_W'(NUM_SLOTS - 1));
		unique case (req_q)
			REQ_TICK: sts.go_yield = preemptive_mode;
			REQ_YIELD: sts.go_yield = 1'b1;
			REQ_STOP: sts.go_yield = cur_nz;
			REQ_SUSPEND: sts.go_yield = susp_ok && (addr == cur_q);
			REQ_DELAY: sts.go_yield = cur_nz;
			default: sts.go_yield = 1'b0;
		endcase
		unique case (cmd.phase)
			PH_CREATE: sts.hit = (rd_state == SS_UNUSED);
			PH_SCAN: sts.hit = (rd_state == SS_READY);
			default: sts.hit = 1'b0;
		endcase
	end

	always_comb begin
		st_we = 1'b0;
		dl_we = 1'b0;
		wr_state = SS_READY;
		wr_dl = '0;
		unique case (cmd.phase)
			PH_PRE: begin
				unique case (req_q)
					REQ_STOP: begin
						st_we = cur_nz;
						wr_state = SS_UNUSED;
					end
					REQ_SUSPEND: begin
						st_we = susp_ok;
						dl_we = susp_ok;
						wr_state = SS_SUSPENDED;
					end
					REQ_RESUME: begin
						st_we = (rd_state == SS_SUSPENDED);
					end
					REQ_DELAY: begin
						st_we = cur_nz;
						dl_we = cur_nz;
						wr_state = SS_BLOCKED;
						wr_dl = time_q + dms_q;
					end
					default: ;
				endcase
			end
			PH_CREATE: begin
				st_we = sts.hit;
				dl_we = sts.hit;
			end
			PH_WAKE: begin
				st_we = expired;
				dl_we = expired;
			end
			PH_SCAN: begin
				st_we = sts.hit;
				wr_state = SS_RUNNING;
			end
			PH_SWAP: st_we = cur_run_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				slot_state_q[i] <= (i == 0) ? SS_RUNNING : SS_UNUSED;
			end
			cur_q <= '0;
			time_q <= '0;
			req_q <= REQ_YIELD;
			idx_q <= '0;
		end else begin
			if (st_we) begin
				slot_state_q[addr] <= wr_state;
			end
			if (cmd.load) begin
				req_q <= req_type;
				idx_q <= '0;
			end else if (cmd.phase == PH_CREATE || cmd.phase == PH_WAKE ||
				cmd.phase == PH_SCAN) begin
				idx_q <= idx_q + 4'd1;
			end
			if (cmd.phase == PH_PRE && req_q == REQ_TICK) begin
				time_q <= time_q + 32'd1;
			end
			if (cmd.phase == PH_SCAN && sts.hit) begin
				cur_q <= addr;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dl_we) begin
			deadline_q[addr] <= wr_dl;
		end
		if (cmd.load) begin
			tgt_q <= target_slot;
			tcur_q <= target_is_current;
			dms_q <= delay_ms;
			prev_q <= cur_q;
			cnt_q <= '0;
			status_q <= (req_type == REQ_CREATE) ? ST_FULL : ST_DONE;
			handle_q <= '0;
			wait_q <= '0;
			cur_run_q <= 1'b0;
		end
		if (cmd.phase == PH_CREATE && sts.hit) begin
			status_q <= ST_CREATED;
			handle_q <= idx_q;
		end
		if (cmd.phase == PH_SCAN) begin
			if (idx_q == '0) begin
				cur_run_q <= (rd_state == SS_RUNNING);
			end
			if (sts.hit) begin
				old_q <= cur_q;
				status_q <= ST_SWITCHED;
			end else begin
				cnt_q <= cnt_nxt;
				if (sts.last) begin
					status_q <= ST_NO_READY;
					wait_q <= cnt_nxt;
				end
			end
		end
	end

	assign res.status = status_q;
	assign res.running = cur_q;
	assign res.previous = prev_q;
	assign res.handle = handle_q;
	assign res.waiting = wait_q;
endmodule
`default_nettype wire

@@ sv/rrts_ctrl.sv @@
// Sequencing state machine of the thread scheduler.
// Commands rrts_dp through cmd_t and reads its sts_t; depends on rrts_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rrts_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic out_free,
	input wire rrts_pkg::sts_t sts,
	output logic in_ready,
	output logic out_load,
	output rrts_pkg::cmd_t cmd
);
	import rrts_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_PRE = 7'b0000010,
		S_CREATE = 7'b0000100,
		S_WAKE = 7'b0001000,
		S_SCAN = 7'b0010000,
		S_SWAP = 7'b0100000,
		S_FIN = 7'b1000000
	} state_t;

	state_t state_q, state_nxt;

	always_comb begin
		state_nxt = state_q;
		cmd.load = 1'b0;
		cmd.phase = PH_IDLE;
		out_load = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				cmd.load = in_valid;
				if (in_valid) begin
					state_nxt = S_PRE;
				end
			end
			S_PRE: begin
				cmd.phase = PH_PRE;
				if (sts.is_create) begin
					state_nxt = S_CREATE;
				end else if (sts.go_yield) begin
					state_nxt = sts.go_wake ? S_WAKE : S_SCAN;
				end else begin
					state_nxt = S_FIN;
				end
			end
			S_CREATE: begin
				cmd.phase = PH_CREATE;
				if (sts.hit || sts.last) begin
					state_nxt = S_FIN;
				end
			end
			S_WAKE: begin
				cmd.phase = PH_WAKE;
				if (sts.last) begin
					state_nxt = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.phase = PH_SCAN;
				if (sts.hit) begin
					state_nxt = S_SWAP;
				end else if (sts.last) begin
					state_nxt = S_FIN;
				end
			end
			S_SWAP: begin
				cmd.phase = PH_SWAP;
				state_nxt = S_FIN;
			end
			S_FIN: begin
				cmd.phase = PH_FIN;
				out_load = out_free;
				if (out_free) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	assign in_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end
endmodule
`default_nettype wire

@@ sim/round_robin_thread_scheduler_unit_tb.sv @@
`timescale 1ns / 1ps
// Testbench for round_robin_thread_scheduler_unit: directed and random scheduler requests
// checked word by word against a slot-table predictor kept inside this file.
// Depends on rrts_pkg and the scheduler RTL only.
module round_robin_thread_scheduler_unit_tb;
	import rrts_pkg::*;

	localparam logic [2:0] REQ_UNDEFINED = 3'd7;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic cfg_wr_data = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [39:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;

	logic [2:0] slot_st [NUM_SLOTS];
	logic [31:0] slot_deadline [NUM_SLOTS];
	logic [SLOT_W-1:0] cur_slot;
	logic [31:0] now_ms;
	logic preempt;

	res_t due_results [$];
	res_t want;
	res_t got;
	int errors = 0;
	int idle_cycles = 0;
	int rx_hold_cycles = 0;
	bit tx_calm = 1'b0;
	bit rx_calm = 1'b0;

	round_robin_thread_scheduler_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #2 clk = ~clk;

	function automatic logic [2:0] pick_next_thread(input bit wake, output logic [CNT_W-1:0] waiting);
		int unsigned i;
		int unsigned p;
		int unsigned cnt;
		logic [31:0] diff;
		waiting = '0;
		cnt = 0;
		if (wake) begin
			for (i = 0; i < NUM_SLOTS; i++) begin
				diff = now_ms - slot_deadline[i];
				if (slot_st[i] == SS_BLOCKED && diff < 32'h8000_0000) begin
					slot_deadline[i] = '0;
					slot_st[i] = SS_READY;
				end
			end
		end
		for (i = 0; i < NUM_SLOTS; i++) begin
			p = (cur_slot + i) % NUM_SLOTS;
			if (slot_st[p] == SS_READY) begin
				if (slot_st[cur_slot] == SS_RUNNING)
					slot_st[cur_slot] = SS_READY;
				slot_st[p] = SS_RUNNING;
				cur_slot = p[SLOT_W-1:0];
				return ST_SWITCHED;
			end
			if (slot_st[p] == SS_BLOCKED || slot_st[p] == SS_SUSPENDED)
				cnt++;
		end
		waiting = (cnt > 31) ? CNT_MAX : cnt[CNT_W-1:0];
		return ST_NO_READY;
	endfunction

	function automatic res_t schedule_request(input logic [2:0] req, input logic [SLOT_W-1:0] slot,
			input logic use_cur, input logic [31:0] dms);
		res_t r;
		int unsigned i;
		logic [SLOT_W-1:0] p;
		logic [CNT_W-1:0] w;
		bit found;
		r = '0;
		w = '0;
		found = 1'b0;
		r.previous = cur_slot;
		r.status = ST_DONE;
		case (req)
			REQ_TICK: begin
				now_ms = now_ms + 32'd1;
				if (preempt)
					r.status = pick_next_thread(1'b1, w);
			end
			REQ_YIELD: r.status = pick_next_thread(!preempt, w);
			REQ_CREATE: begin
				r.status = ST_FULL;
				for (i = 0; i < NUM_SLOTS; i++) begin
					if (!found && slot_st[i] == SS_UNUSED) begin
						found = 1'b1;
						slot_st[i] = SS_READY;
						slot_deadline[i] = '0;
						r.status = ST_CREATED;
						r.handle = i[SLOT_W-1:0];
					end
				end
			end
			REQ_STOP: begin
				if (cur_slot != 0) begin
					slot_st[cur_slot] = SS_UNUSED;
					r.status = pick_next_thread(!preempt, w);
				end
			end
			REQ_SUSPEND: begin
				p = use_cur ? cur_slot : slot;
				if (slot_st[p] == SS_RUNNING || slot_st[p] == SS_READY || slot_st[p] == SS_BLOCKED) begin
					slot_st[p] = SS_SUSPENDED;
					slot_deadline[p] = '0;
					if (p == cur_slot)
						r.status = pick_next_thread(!preempt, w);
				end
			end
			REQ_RESUME: begin
				if (slot_st[slot] == SS_SUSPENDED)
					slot_st[slot] = SS_READY;
			end
			REQ_DELAY: begin
				if (cur_slot != 0) begin
					slot_deadline[cur_slot] = now_ms + dms;
					slot_st[cur_slot] = SS_BLOCKED;
					r.status = pick_next_thread(!preempt, w);
				end
			end
			default: ;
		endcase
		r.running = cur_slot;
		r.waiting = w;
		return r;
	endfunction

	function automatic void check_field(input string label, input int unsigned want_v,
			input int unsigned got_v);
		if (want_v != got_v) begin
			errors++;
			$display("%0t ns: %s expected %0d, got %0d", $time, label, want_v, got_v);
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (due_results.size() == 0) begin
				errors++;
				$display("%0t ns: result word expected none, got %h", $time, m_axis_tdata);
			end else begin
				want = due_results.pop_front();
				got = res_t'(m_axis_tdata[19:0]);
				check_field("status", want.status, got.status);
				check_field("running_slot", want.running, got.running);
				check_field("previous_slot", want.previous, got.previous);
				check_field("new_handle", want.handle, got.handle);
				check_field("waiting_count", want.waiting, got.waiting);
				check_field("padding", 0, m_axis_tdata[23:20]);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t ns: no word moved for %0d cycles", $time, idle_cycles);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		int hold;
		int stall;
		do @(posedge clk); while (!arst_n);
		forever begin
			if (rx_hold_cycles != 0) begin
				hold = rx_hold_cycles;
				rx_hold_cycles = 0;
				m_axis_tready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			stall = rx_calm ? 0 : $urandom_range(0, 8);
			if (stall != 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
		end
	end

	task automatic send_request(input logic [2:0] req, input logic [SLOT_W-1:0] slot,
			input logic use_cur, input logic [31:0] dms);
		int gap;
		gap = tx_calm ? 0 : $urandom_range(0, 8);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {dms, use_cur, slot, req};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		due_results.push_back(schedule_request(req, slot, use_cur, dms));
	endtask

	task automatic send_random_request();
		int unsigned pick;
		logic [2:0] req;
		logic [31:0] dms;
		pick = $urandom_range(0, 99);
		if (pick < 20) req = REQ_TICK;
		else if (pick < 38) req = REQ_YIELD;
		else if (pick < 52) req = REQ_CREATE;
		else if (pick < 60) req = REQ_STOP;
		else if (pick < 72) req = REQ_SUSPEND;
		else if (pick < 86) req = REQ_RESUME;
		else if (pick < 98) req = REQ_DELAY;
		else req = REQ_UNDEFINED;
		case ($urandom_range(0, 7))
			0, 1, 2: dms = $urandom_range(0, 12);
			3: dms = $urandom_range(0, 200);
			4: dms = $urandom;
			5: dms = 32'hFFFF_FFFF - $urandom_range(0, 3);
			6: dms = 32'h8000_0000 + $urandom_range(0, 3);
			default: dms = 32'h7FFF_FFFF - $urandom_range(0, 3);
		endcase
		send_request(req, SLOT_W'($urandom_range(0, NUM_SLOTS - 1)), 1'($urandom_range(0, 1)),
			dms);
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
	endtask

	task automatic set_mode(input logic mode);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= mode;
		@(posedge clk);
		preempt = mode;
		cfg_wr_en <= 1'b0;
	endtask

	task automatic test_main_thread_rules();
		set_mode(1'b0);
		send_request(REQ_TICK, 4'd0, 1'b0, 32'd0);
		send_request(REQ_YIELD, 4'd0, 1'b0, 32'd0);
		send_request(REQ_STOP, 4'd0, 1'b0, 32'd0);
		send_request(REQ_DELAY, 4'd0, 1'b0, 32'hFFFF_FFFF);
		send_request(REQ_UNDEFINED, 4'd15, 1'b1, 32'hFFFF_FFFF);
		send_request(REQ_RESUME, 4'd3, 1'b0, 32'd0);
		send_request(REQ_SUSPEND, 4'd5, 1'b0, 32'd0);
	endtask

	task automatic test_cooperative_switching();
		send_request(REQ_CREATE, 4'd0, 1'b0, 32'd0);
		send_request(REQ_CREATE, 4'd0, 1'b0, 32'd0);
		send_request(REQ_YIELD, 4'd0, 1'b0, 32'd0);
		send_request(REQ_DELAY, 4'd0, 1'b0, 32'hFFFF_FFFF);
		send_request(REQ_SUSPEND, 4'd9, 1'b1, 32'd0);
		send_request(REQ_STOP, 4'd0, 1'b0, 32'd0);
		send_request(REQ_SUSPEND, 4'd0, 1'b0, 32'd0);
		send_request(REQ_RESUME, 4'd0, 1'b0, 32'd0);
		send_request(REQ_YIELD, 4'd0, 1'b0, 32'd0);
		send_request(REQ_RESUME, 4'd1, 1'b0, 32'd0);
		send_request(REQ_DELAY, 4'd0, 1'b0, 32'h8000_0000);
	endtask

	task automatic test_preemptive_ticks();
		wait_idle();
		set_mode(1'b1);
		send_request(REQ_TICK, 4'd0, 1'b0, 32'd0);
		send_request(REQ_DELAY, 4'd0, 1'b0, 32'd3);
		send_request(REQ_YIELD, 4'd0, 1'b0, 32'd0);
		repeat (3) send_request(REQ_TICK, 4'd0, 1'b0, 32'd0);
		send_request(REQ_CREATE, 4'd0, 1'b0, 32'd0);
		send_request(REQ_TICK, 4'd0, 1'b0, 32'd0);
	endtask

	task automatic test_random_mix(input int count, input logic mode);
		wait_idle();
		set_mode(mode);
		repeat (count) send_random_request();
	endtask

	task automatic test_back_to_back(input int count);
		tx_calm = 1'b1;
		rx_calm = 1'b1;
		repeat (count) send_random_request();
		tx_calm = 1'b0;
		rx_calm = 1'b0;
	endtask

	task automatic test_backpressure(input int count);
		rx_hold_cycles = 300;
		tx_calm = 1'b1;
		repeat (count) send_random_request();
		tx_calm = 1'b0;
	endtask

	initial begin
		int i;
		for (i = 0; i < NUM_SLOTS; i++) begin
			slot_st[i] = SS_UNUSED;
			slot_deadline[i] = '0;
		end
		slot_st[0] = SS_RUNNING;
		cur_slot = '0;
		now_ms = '0;
		preempt = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_main_thread_rules();
		test_cooperative_switching();
		test_preemptive_ticks();
		test_random_mix(400, 1'b0);
		test_random_mix(400, 1'b1);
		test_back_to_back(150);
		test_backpressure(40);
		test_random_mix(400, 1'b0);
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

@@ filelist.f @@
+incdir+sv
sv/rrts_pkg.sv
sv/rrts_dp.sv
sv/rrts_ctrl.sv
sv/round_robin_thread_scheduler_unit.sv
sim/round_robin_thread_scheduler_unit_tb.sv
